>>> sv/diff_drive_move_turn_controller_core_defines.svh
// Assertion helpers, clocked on i_clk and disabled while i_rst_n is low.
`ifndef DIFF_DRIVE_MOVE_TURN_CONTROLLER_CORE_DEFINES_SVH
`define DIFF_DRIVE_MOVE_TURN_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication.
`define DDMTC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DDMTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ddmtc_pkg.sv
package ddmtc_pkg;

    // command codes carried in tuser
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_MOVE = 2'd1;
    localparam logic [1:0] CMD_TURN = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W = 1;
    localparam logic       CFG_SPEED = 1'b0;
    localparam logic       CFG_DIST  = 1'b1;

    // distance thresholds searched per move step
    localparam int         SPEED_LEVELS = 4;

    // heading units: 1/16 degree
    localparam logic [12:0]        HD_HALF     = 13'd2880;
    localparam logic signed [13:0] HD_FULL     = 14'sd5760;
    localparam logic signed [15:0] AMT_HALF    = 16'sd180;
    localparam logic signed [16:0] AMT_FULL    = 17'sd360;
    localparam logic signed [20:0] TURN_NEAR   = 21'sd320;
    localparam logic signed [20:0] TURN_DONE   = 21'sd16;
    localparam logic signed [15:0] DRIVE_LIMIT = 16'sd255;

    typedef struct packed {
        logic       dir;
        logic [7:0] mag;
    } t_drive;

    // clamp to +-255, split into direction (positive) and magnitude
    function automatic t_drive f_drive(input logic signed [15:0] d);
        logic signed [15:0] neg;
        t_drive             res;
        neg     = -d;
        res.dir = (d > 16'sd0);
        if (d > DRIVE_LIMIT || d < -DRIVE_LIMIT) begin
            res.mag = 8'hFF;
        end else if (d > 16'sd0) begin
            res.mag = d[7:0];
        end else begin
            res.mag = neg[7:0];
        end
        return res;
    endfunction

endpackage

>>> sv/diff_drive_move_turn_controller_core.sv
// Start-move, start-turn and unused commands are accepted in IDLE and need no further states.
// Tick with a move active: bit-serial squaring (dx then dy), digit-by-digit square root,
// then speed select/correction (S_MV0, S_MV1, S_MV2); the move word is loaded from S_MV2
// once the output is free, and an active turn adds its word from S_TRN after it. No new input
// word is taken until IDLE. Tick with only a turn active goes to S_TRN; with nothing active it stays in IDLE.
// Reset (i_rst_n low, synchronous) clears both tables, move/turn state and the output valid flag.
`include "diff_drive_move_turn_controller_core_defines.svh"

module diff_drive_move_turn_controller_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ddmtc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [63:0]                           i_cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // pos_x[15:0], pos_y[31:16], heading[44:32], amount[60:45], zero[63:61]
    input  logic [63:0]                           s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // left_ccw[0], left_speed[8:1], right_cw[9], right_speed[17:10], zero[23:18]
    output logic [23:0]                           m_axis_tdata,
    // from_turn[0]
    output logic                                  m_axis_tuser,
    output logic                                  m_axis_tlast
);
    import ddmtc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_SQRT = 3'd2;
    localparam logic [2:0] S_MV0  = 3'd3;
    localparam logic [2:0] S_MV1  = 3'd4;
    localparam logic [2:0] S_MV2  = 3'd5;
    localparam logic [2:0] S_TRN  = 3'd6;

    // control and state
    logic [2:0]         r_state;
    logic [4:0]         r_cnt;
    logic [31:0]        r_speed_tab;
    logic [63:0]        r_dist_tab;
    logic               r_move_active;
    logic               r_turn_active;
    logic               r_fwd;
    logic [15:0]        r_goal;
    logic signed [15:0] r_start_x;
    logic signed [15:0] r_start_y;
    logic signed [12:0] r_start_hd;
    logic signed [19:0] r_turn_goal;
    logic               r_m_valid;

    // datapath
    logic signed [13:0] r_err;
    logic signed [20:0] r_trem;
    logic [15:0]        r_ady;
    logic [15:0]        r_mplr;
    logic [31:0]        r_mcand;
    logic [33:0]        r_acc;
    logic [33:0]        r_val;
    logic [16:0]        r_root;
    logic [17:0]        r_rem;
    logic               r_stop;
    logic [7:0]         r_sp;
    logic signed [15:0] r_corr;
    logic signed [15:0] r_q;
    logic signed [15:0] r_vg;
    logic signed [15:0] r_vd;
    t_drive             r_m_left;
    t_drive             r_m_right;
    logic               r_m_turn;
    logic               r_m_last;

    // input word fields
    logic [1:0]         in_cmd;
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;
    logic [12:0]        in_hd;
    logic signed [15:0] in_amt;

    assign in_cmd = s_axis_tuser;
    assign in_x   = s_axis_tdata[15:0];
    assign in_y   = s_axis_tdata[31:16];
    assign in_hd  = s_axis_tdata[44:32];
    assign in_amt = s_axis_tdata[60:45];

    logic in_acc;
    logic out_free;
    logic emit;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign emit          = out_free && (r_state == S_MV2 || r_state == S_TRN);

    // ---------------- accept-cycle arithmetic ----------------
    logic signed [16:0] dx, dy;
    logic [16:0]        adx, ady;
    logic signed [13:0] hd_w;
    logic signed [14:0] err_w;
    logic signed [16:0] amt_w;
    logic [16:0]        amt_neg;
    logic signed [19:0] tg_w;
    logic signed [20:0] trem_w;

    always_comb begin
        dx      = {in_x[15], in_x} - {r_start_x[15], r_start_x};
        dy      = {in_y[15], in_y} - {r_start_y[15], r_start_y};
        adx     = dx[16] ? -dx : dx;
        ady     = dy[16] ? -dy : dy;
        // heading above half a turn wraps once
        hd_w    = (in_hd > HD_HALF) ? ({1'b0, in_hd} - HD_FULL) : {1'b0, in_hd};
        err_w   = {hd_w[13], hd_w} - {{2{r_start_hd[12]}}, r_start_hd};
        amt_w   = (in_amt > AMT_HALF) ? ({in_amt[15], in_amt} - AMT_FULL)
                                      : {in_amt[15], in_amt};
        amt_neg = -{in_amt[15], in_amt};
        tg_w    = {amt_w[15:0], 4'b0000};
        trem_w  = {r_turn_goal[19], r_turn_goal} - {{7{hd_w[13]}}, hd_w};
    end

    // ---------------- serial square / square root ----------------
    logic [33:0] acc_n;
    logic [19:0] rem_sh;
    logic [19:0] trial;
    logic [19:0] rem_sub;
    logic        root_ge;

    always_comb begin
        acc_n   = r_acc + (r_mplr[0] ? {2'b00, r_mcand} : 34'd0);
        rem_sh  = {r_rem, r_val[33:32]};
        trial   = {1'b0, r_root, 2'b01};
        root_ge = (rem_sh >= trial);
        rem_sub = rem_sh - trial;
    end

    // ---------------- speed search ----------------
    logic signed [17:0] remd;
    logic [SPEED_LEVELS-1:0] fit;
    logic               fit_any;
    logic [1:0]         fit_idx;

    always_comb begin
        remd    = $signed({2'b00, r_goal}) - $signed({1'b0, r_root});
        fit_any = 1'b0;
        fit_idx = 2'd0;
        for (int i = 0; i < SPEED_LEVELS; i++) begin
            fit[i] = !remd[17] && (remd[16:0] >= {1'b0, r_dist_tab[16*i +: 16]});
        end
        for (int i = SPEED_LEVELS - 1; i >= 0; i--) begin
            if (fit[i]) begin
                fit_any = 1'b1;
                fit_idx = 2'(i);
            end
        end
    end

    // ---------------- drive assembly ----------------
    logic signed [15:0] spv, vg, vd, vbase, q_n, q3, tq, dl, dr;
    logic               err_pos, err_neg;
    logic               turn_near;
    logic [7:0]         tsp;
    logic signed [15:0] tdrv;
    logic               turn_stop;

    always_comb begin
        spv     = {8'b0, r_sp};
        vg      = r_fwd ? spv : -spv;
        vd      = -vg;
        vbase   = r_err[13] ? vg : vd;
        q_n     = r_fwd ? ((vbase <<< 2) - r_corr) : ((vbase <<< 2) + r_corr);

        // quarter units truncated toward zero
        q3      = r_q + 16'sd3;
        tq      = r_q[15] ? (q3 >>> 2) : (r_q >>> 2);
        err_neg = r_err[13];
        err_pos = !r_err[13] && (r_err != 14'sd0);
        dl      = r_stop ? 16'sd0 : (err_neg ? tq : r_vg);
        dr      = r_stop ? 16'sd0 : (err_pos ? tq : r_vd);

        // turn: speed level 3 inside 20 degrees, level 1 outside, done inside 1 degree
        turn_near = (r_trem > -TURN_NEAR) && (r_trem < TURN_NEAR);
        tsp       = turn_near ? r_speed_tab[31:24] : r_speed_tab[15:8];
        turn_stop = 1'b0;
        if (r_trem > TURN_DONE) begin
            tdrv = {8'b0, tsp};
        end else if (r_trem < -TURN_DONE) begin
            tdrv = -$signed({8'b0, tsp});
        end else begin
            tdrv      = 16'sd0;
            turn_stop = 1'b1;
        end
    end

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt         <= 5'd0;
            r_speed_tab   <= 32'd0;
            r_dist_tab    <= 64'd0;
            r_move_active <= 1'b0;
            r_turn_active <= 1'b0;
            r_fwd         <= 1'b0;
            r_goal        <= 16'd0;
            r_start_x     <= 16'sd0;
            r_start_y     <= 16'sd0;
            r_start_hd    <= 13'sd0;
            r_turn_goal   <= 20'sd0;
            r_m_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SPEED: r_speed_tab <= i_cfg_data[31:0];
                    CFG_DIST:  r_dist_tab  <= i_cfg_data;
                    default:   ;
                endcase
            end

            if (emit) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (in_cmd)
                            CMD_MOVE: begin
                                r_fwd         <= !in_amt[15];
                                r_goal        <= in_amt[15] ? amt_neg[15:0] : in_amt;
                                r_start_x     <= in_x;
                                r_start_y     <= in_y;
                                r_start_hd    <= hd_w[12:0];
                                r_move_active <= 1'b1;
                            end
                            CMD_TURN: begin
                                r_turn_goal   <= tg_w;
                                r_turn_active <= 1'b1;
                            end
                            CMD_TICK: begin
                                r_cnt <= 5'd0;
                                if (r_move_active) begin
                                    r_state <= S_SQ;
                                end else if (r_turn_active) begin
                                    r_state <= S_TRN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SQ: begin
                    if (r_cnt == 5'd31) begin
                        r_cnt   <= 5'd0;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_SQRT: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd16) begin
                        r_state <= S_MV0;
                    end
                end
                S_MV0: r_state <= S_MV1;
                S_MV1: r_state <= S_MV2;
                S_MV2: begin
                    if (out_free) begin
                        if (r_stop) begin
                            r_move_active <= 1'b0;
                        end
                        r_state <= r_turn_active ? S_TRN : S_IDLE;
                    end
                end
                S_TRN: begin
                    if (out_free) begin
                        if (turn_stop) begin
                            r_turn_active <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc && in_cmd == CMD_TICK) begin
            r_err   <= err_w[13:0];
            r_trem  <= trem_w;
            r_acc   <= 34'd0;
            r_mplr  <= adx[15:0];
            r_mcand <= {16'b0, adx[15:0]};
            r_ady   <= ady[15:0];
        end

        if (r_state == S_SQ) begin
            r_acc <= acc_n;
            if (r_cnt == 5'd15) begin
                // dx done, start on dy
                r_mplr  <= r_ady;
                r_mcand <= {16'b0, r_ady};
            end else begin
                r_mplr  <= r_mplr >> 1;
                r_mcand <= r_mcand << 1;
            end
            if (r_cnt == 5'd31) begin
                r_val  <= acc_n;
                r_root <= 17'd0;
                r_rem  <= 18'd0;
            end
        end

        if (r_state == S_SQRT) begin
            r_val  <= r_val << 2;
            r_root <= {r_root[15:0], root_ge};
            r_rem  <= root_ge ? rem_sub[17:0] : rem_sh[17:0];
        end

        if (r_state == S_MV0) begin
            r_stop <= !fit_any;
            r_sp   <= r_speed_tab[{fit_idx, 3'b000} +: 8];
            r_corr <= {r_err, 2'b00} + {{2{r_err[13]}}, r_err};
        end

        if (r_state == S_MV1) begin
            r_q  <= q_n;
            r_vg <= vg;
            r_vd <= vd;
        end

        if (emit) begin
            if (r_state == S_MV2) begin
                r_m_left  <= f_drive(dl);
                r_m_right <= f_drive(dr);
                r_m_turn  <= 1'b0;
                r_m_last  <= !r_turn_active;
            end else begin
                r_m_left  <= f_drive(tdrv);
                r_m_right <= f_drive(tdrv);
                r_m_turn  <= 1'b1;
                r_m_last  <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'b0, r_m_right.mag, r_m_right.dir, r_m_left.mag, r_m_left.dir};
    assign m_axis_tuser  = r_m_turn;
    assign m_axis_tlast  = r_m_last;

    // ---------------- assertions ----------------
    `DDMTC_ASSERT_IMP(a_turn_word_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast,
        "turn word not marked last")
    `DDMTC_ASSERT_IMP(a_dir_has_speed, m_axis_tvalid && m_axis_tdata[0],
        m_axis_tdata[8:1] != 8'd0, "left direction set with zero speed")
    `DDMTC_ASSERT_IMP(a_move_stop_word, $past(i_rst_n) && $fell(r_move_active),
        m_axis_tvalid && !m_axis_tuser && (m_axis_tdata == 24'd0),
        "move ended without a stop word")
    `DDMTC_ASSERT_IMP(a_turn_stop_word, $past(i_rst_n) && $fell(r_turn_active),
        m_axis_tvalid && m_axis_tuser && (m_axis_tdata == 24'd0),
        "turn ended without a stop word")
    `DDMTC_ASSERT_NEXT(a_move_emit, r_state == S_MV2 && out_free,
        m_axis_tvalid && !m_axis_tuser, "move word not loaded")

endmodule
